FILE: hw/rtl/ladq_pkg.sv
// ladq_pkg: shared types and constants of the linear array deque
// holds the depth, index width, command and status codes, and controller commands
// depends on nothing

package ladq_pkg;

  // storage geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // payload widths
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2
  } stat_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture an incoming transaction
    logic exec;  // update indices and access the slot array
  } ctrl_cmd_t;

endpackage

FILE: hw/rtl/ladq_ctrl.sv
// ladq_ctrl: controller state machine of the linear array deque
// sequences load, execute and result handoff for one transaction at a time
// depends on ladq_pkg

module ladq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output ladq_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // handshake and datapath commands
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign cmd.load   = in_tready && in_tvalid;
  assign cmd.exec   = (state_r == S_EXEC);

endmodule

FILE: hw/rtl/ladq_dp.sv
// ladq_dp: datapath of the linear array deque
// holds the slot memory, front and rear indices, empty flag and result registers
// depends on ladq_pkg

module ladq_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ladq_pkg::ctrl_cmd_t                   cmd,
  input  logic [ladq_pkg::CMD_W-1:0]            in_command,
  input  logic signed [ladq_pkg::DATA_W-1:0]    in_value,
  output logic [ladq_pkg::STAT_W-1:0]           out_status,
  output logic signed [ladq_pkg::DATA_W-1:0]    out_element
);

  logic signed [ladq_pkg::DATA_W-1:0] mem [ladq_pkg::DEPTH];

  ladq_pkg::cmd_t                     cmd_r;
  logic signed [ladq_pkg::DATA_W-1:0] val_r;
  logic [ladq_pkg::IDX_W-1:0]         front_r, front_nxt;
  logic [ladq_pkg::IDX_W-1:0]         rear_r, rear_nxt;
  logic                               empty_r, empty_nxt;
  ladq_pkg::stat_t                    status_r, status_nxt;
  logic                               from_mem_r, from_mem_nxt;
  logic signed [ladq_pkg::DATA_W-1:0] rd_data_r;
  logic [ladq_pkg::IDX_W-1:0]         addr;
  logic                               wr_en;

  // capture the incoming transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= ladq_pkg::cmd_t'(in_command);
      val_r <= in_value;
    end
  end

  // command decode against the current indices
  always_comb begin
    front_nxt    = front_r;
    rear_nxt     = rear_r;
    empty_nxt    = empty_r;
    status_nxt   = ladq_pkg::STAT_OK;
    from_mem_nxt = 1'b0;
    addr         = front_r;
    wr_en        = 1'b0;
    unique case (cmd_r)
      ladq_pkg::CMD_PUSH_FRONT, ladq_pkg::CMD_PUSH_BACK: begin
        if (empty_r) begin
          // empty deque always refills from slot zero
          empty_nxt = 1'b0;
          front_nxt = '0;
          rear_nxt  = '0;
          addr      = '0;
          wr_en     = 1'b1;
        end else if (cmd_r == ladq_pkg::CMD_PUSH_FRONT) begin
          if (front_r == '0) begin
            status_nxt = ladq_pkg::STAT_OVERFLOW;
          end else begin
            front_nxt = front_r - ladq_pkg::IDX_W'(1);
            addr      = front_r - ladq_pkg::IDX_W'(1);
            wr_en     = 1'b1;
          end
        end else begin
          if (rear_r == ladq_pkg::LAST_IDX) begin
            status_nxt = ladq_pkg::STAT_OVERFLOW;
          end else begin
            rear_nxt = rear_r + ladq_pkg::IDX_W'(1);
            addr     = rear_r + ladq_pkg::IDX_W'(1);
            wr_en    = 1'b1;
          end
        end
      end
      ladq_pkg::CMD_POP_FRONT, ladq_pkg::CMD_POP_BACK: begin
        if (empty_r) begin
          status_nxt = ladq_pkg::STAT_EMPTY;
        end else if (front_r == rear_r) begin
          // last element leaves, deque goes back to empty
          from_mem_nxt = 1'b1;
          addr         = front_r;
          empty_nxt    = 1'b1;
          front_nxt    = '0;
          rear_nxt     = '0;
        end else if (cmd_r == ladq_pkg::CMD_POP_FRONT) begin
          from_mem_nxt = 1'b1;
          addr         = front_r;
          front_nxt    = front_r + ladq_pkg::IDX_W'(1);
        end else begin
          from_mem_nxt = 1'b1;
          addr         = rear_r;
          rear_nxt     = rear_r - ladq_pkg::IDX_W'(1);
        end
      end
      default: begin
        status_nxt = ladq_pkg::STAT_OK;
      end
    endcase
  end

  // index and empty flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r   <= status_nxt;
      from_mem_r <= from_mem_nxt;
    end
  end

  // slot memory, at most one write and one registered read per command
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) begin
        mem[addr] <= val_r;
      end
      rd_data_r <= mem[addr];
    end
  end

  // result select
  assign out_status  = status_r;
  assign out_element = (status_r != ladq_pkg::STAT_OK) ? '0 :
                       (from_mem_r ? rd_data_r : val_r);

endmodule

FILE: hw/rtl/linear_array_deque.sv
// linear_array_deque: top level of the linear (non-wrapping) array deque
// joins the controller ladq_ctrl and the datapath ladq_dp
// depends on ladq_pkg, ladq_ctrl, ladq_dp
//
//  channel  | direction | tuser               | tdata
//  ---------+-----------+---------------------+----------------------------
//  in_      | slave     | [1:0] command       | [31:0] value (signed)
//  out_     | master    | [1:0] status        | [31:0] element (signed)
//
// one command is handled at a time: accept, an execute state for the index
// update and the single slot memory access, then the result is offered
// the result is held in registers, as the read port of the slot memory is
// registered; a low out_tready stretches the result cycle
// rst_n (synchronous) empties the deque; slot contents are not cleared
// in_tready is low from acceptance until the result transaction completes

module linear_array_deque (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] element
  output logic [1:0]  out_tuser   // [1:0] status
);

  ladq_pkg::ctrl_cmd_t                  cmd;
  logic signed [ladq_pkg::DATA_W-1:0]   element;

  // controller
  ladq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // datapath
  ladq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_command  (in_tuser),
    .in_value    (in_tdata),
    .out_status  (out_tuser),
    .out_element (element)
  );

  assign out_tdata = element;

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for linear_array_deque, one file
// predicts every command result with its own deque model, checks results in order
// depends on ladq_pkg and the linear_array_deque rtl
`timescale 1ns / 100ps

module testbench;

  // expected result of one command
  typedef struct packed {
    ladq_pkg::stat_t             status;
    logic [ladq_pkg::DATA_W-1:0] element;
  } deque_result_t;

  logic                        clk;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [ladq_pkg::DATA_W-1:0] in_tdata   = '0;  // [31:0] value
  logic [ladq_pkg::CMD_W-1:0]  in_tuser   = '0;  // [1:0] command
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [ladq_pkg::DATA_W-1:0] out_tdata;        // [31:0] element
  logic [ladq_pkg::STAT_W-1:0] out_tuser;        // [1:0] status

  // predicted deque contents
  logic [ladq_pkg::DATA_W-1:0] model_slots [ladq_pkg::DEPTH];
  logic [ladq_pkg::IDX_W-1:0]  model_front;
  logic [ladq_pkg::IDX_W-1:0]  model_rear;
  logic                        model_empty;

  deque_result_t     pending_results [$];
  int                error_count = 0;
  int                idle_pct    = 0;
  int                stall_pct   = 0;

  linear_array_deque uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // apply one command to the predicted deque and return its result
  function automatic deque_result_t apply_deque_cmd(ladq_pkg::cmd_t cmd,
                                                    logic [ladq_pkg::DATA_W-1:0] value);
    deque_result_t res;
    res.status  = ladq_pkg::STAT_OK;
    res.element = '0;
    case (cmd)
      ladq_pkg::CMD_PUSH_FRONT, ladq_pkg::CMD_PUSH_BACK: begin
        if (model_empty) begin
          // empty deque always refills from slot 0
          model_empty    = 1'b0;
          model_front    = '0;
          model_rear     = '0;
          model_slots[0] = value;
          res.element    = value;
        end else if (cmd == ladq_pkg::CMD_PUSH_FRONT) begin
          if (model_front == '0) begin
            res.status = ladq_pkg::STAT_OVERFLOW;
          end else begin
            model_front              = model_front - ladq_pkg::IDX_W'(1);
            model_slots[model_front] = value;
            res.element              = value;
          end
        end else begin
          if (model_rear == ladq_pkg::LAST_IDX) begin
            res.status = ladq_pkg::STAT_OVERFLOW;
          end else begin
            model_rear              = model_rear + ladq_pkg::IDX_W'(1);
            model_slots[model_rear] = value;
            res.element             = value;
          end
        end
      end
      default: begin
        if (model_empty) begin
          res.status = ladq_pkg::STAT_EMPTY;
        end else if (model_front == model_rear) begin
          // last element leaves, back to empty
          res.element = model_slots[model_front];
          model_empty = 1'b1;
          model_front = '0;
          model_rear  = '0;
        end else if (cmd == ladq_pkg::CMD_POP_FRONT) begin
          res.element = model_slots[model_front];
          model_front = model_front + ladq_pkg::IDX_W'(1);
        end else begin
          res.element = model_slots[model_rear];
          model_rear  = model_rear - ladq_pkg::IDX_W'(1);
        end
      end
    endcase
    return res;
  endfunction

  // send one command, record its prediction once the transaction completes
  task automatic send_cmd(ladq_pkg::cmd_t cmd, logic [ladq_pkg::DATA_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_deque_cmd(cmd, value));
  endtask

  // hold off the sender until every predicted result has been seen
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d element %0d",
                 $time, out_tuser, $signed(out_tdata));
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, out_tuser);
          error_count++;
        end
        if (out_tdata !== want.element) begin
          $display("%0t: element mismatch, expected %0d actual %0d",
                   $time, $signed(want.element), $signed(out_tdata));
          error_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // pops on an empty deque
  task automatic test_empty_pops();
    send_cmd(ladq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF);
    send_cmd(ladq_pkg::CMD_POP_BACK, 32'h0000_0000);
  endtask

  // single element: push front on empty, front overflow at slot 0, pop of the only element
  task automatic test_single_element();
    send_cmd(ladq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_cmd(ladq_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
    send_cmd(ladq_pkg::CMD_POP_BACK, 32'hA5A5_A5A5);
  endtask

  // fill from the back to the last slot, overflow, then reuse a freed front slot
  task automatic test_fill_to_overflow();
    send_cmd(ladq_pkg::CMD_PUSH_BACK, 32'h8000_0000);
    send_cmd(ladq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
    for (int i = 2; i < ladq_pkg::DEPTH; i++) begin
      send_cmd(ladq_pkg::CMD_PUSH_BACK, (i % 2) ? (32'h1 << i) : ~(32'h1 << i));
    end
    send_cmd(ladq_pkg::CMD_PUSH_BACK, 32'h5A5A_5A5A);
    send_cmd(ladq_pkg::CMD_POP_FRONT, 32'h0);
    send_cmd(ladq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
  endtask

  // random traffic in bursts that lean toward filling, draining or neither
  task automatic run_random_ops(int count);
    int                          left;
    int                          burst;
    int                          lean;
    int                          r;
    bit                          is_push;
    ladq_pkg::cmd_t              cmd;
    logic [ladq_pkg::DATA_W-1:0] value;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(40, 12);
      lean  = $urandom_range(2);
      for (int i = 0; i < burst && left > 0; i++) begin
        r = $urandom_range(99);
        case (lean)
          0:       is_push = (r < 80);
          1:       is_push = (r < 20);
          default: is_push = (r < 50);
        endcase
        if (is_push) begin
          cmd = $urandom_range(1) ? ladq_pkg::CMD_PUSH_BACK : ladq_pkg::CMD_PUSH_FRONT;
        end else begin
          cmd = $urandom_range(1) ? ladq_pkg::CMD_POP_BACK : ladq_pkg::CMD_POP_FRONT;
        end
        case ($urandom_range(15))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7FFF_FFFF;
          2:       value = 32'hFFFF_FFFF;
          3:       value = 32'h0000_0000;
          default: value = $urandom;
        endcase
        send_cmd(cmd, value);
        left--;
      end
    end
  endtask

  task automatic test_traffic_no_idling();
    idle_pct  = 0;
    stall_pct = 0;
    run_random_ops(200);
    wait_results_drained();
  endtask

  task automatic test_traffic_sender_idle();
    idle_pct  = 69;
    stall_pct = 0;
    run_random_ops(200);
    wait_results_drained();
  endtask

  task automatic test_traffic_receiver_stall();
    idle_pct  = 0;
    stall_pct = 69;
    run_random_ops(200);
    wait_results_drained();
  endtask

  task automatic test_traffic_both_idle();
    idle_pct  = 33;
    stall_pct = 33;
    run_random_ops(200);
    wait_results_drained();
  endtask

  // main sequence
  initial begin
    model_empty = 1'b1;
    model_front = '0;
    model_rear  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pops();
    test_single_element();
    test_fill_to_overflow();
    wait_results_drained();

    test_traffic_no_idling();
    test_traffic_sender_idle();
    test_traffic_receiver_stall();
    test_traffic_both_idle();

    // let any stray result show up
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
